### src/xeu_pkg.sv
// Package for the XML entity unescaper: parse modes, character codes,
// entity name patterns, the result bundle type and the code point check.
// No dependencies.
package xeu_pkg;

  typedef enum logic [4:0] {
    MODE_TEXT   = 5'b00001,
    MODE_NAME   = 5'b00010,
    MODE_HASH   = 5'b00100,
    MODE_DIGITS = 5'b01000,
    MODE_ERROR  = 5'b10000
  } xeu_mode_t;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;

  // Entity names as collected, newest byte lowest.
  localparam logic [31:0] NAME_AMP  = 32'h0061_6d70;
  localparam logic [31:0] NAME_LT   = 32'h0000_6c74;
  localparam logic [31:0] NAME_GT   = 32'h0000_6774;
  localparam logic [31:0] NAME_QUOT = 32'h7175_6f74;
  localparam logic [31:0] NAME_APOS = 32'h6170_6f73;

  localparam logic [20:0] CODE_MAX     = 21'h10ffff;
  localparam logic [20:0] DEC_LIMIT    = 21'd111411;  // CODE_MAX / 10
  localparam logic [20:0] HEX_LIMIT    = 21'h010fff;  // CODE_MAX / 16
  localparam logic [20:0] UTF8_2B_BASE = 21'h000080;
  localparam logic [20:0] UTF8_3B_BASE = 21'h000800;
  localparam logic [20:0] UTF8_4B_BASE = 21'h010000;

  // All the results of one input beat: up to four data bytes, then
  // an optional status result.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      dcnt;
    logic [2:0]      total;
    logic            status;
    logic            ok;
  } xeu_res_t;

  function automatic logic valid_char(input logic [20:0] c);
    valid_char = (c == 21'd9) || (c == 21'd10) || (c == 21'd13)
              || (c >= 21'h000020 && c <= 21'h00d7ff)
              || (c >= 21'h00e000 && c <= 21'h00fffd)
              || (c >= 21'h010000 && c <= CODE_MAX);
  endfunction

endpackage

### src/xml_entity_unescape.sv
// Streaming XML entity and character reference decoder; depends on xeu_pkg.
// Each accepted beat passes through the input register and then the result register.
// Throughput: one input beat per cycle while each beat gives at most one result and
// the output is not stalled; a beat with more than one result holds the result register
// until all are taken, as the single output port drains one result per cycle.
// Reset (rst_n low, synchronous) empties both registers and returns to plain text.
module xml_entity_unescape
  import xeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] ok, [15:9] zero
  output logic        out_tuser,  // is_status
  output logic        out_tlast   // result_last
);

  // Input register: one beat waiting to be decoded.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Parser state, updated when a beat moves into the result register.
  xeu_mode_t   mode_r, mode_nxt;
  logic [31:0] name_r, name_nxt;
  logic [2:0]  name_cnt_r, name_cnt_nxt;
  logic [20:0] code_r, code_nxt;
  logic        hex_r, hex_nxt;
  logic        seen_r, seen_nxt;

  // Result register holding every result of one beat, and the read index.
  xeu_res_t   res_r, res_nxt;
  logic       res_valid_r;
  logic [2:0] idx_r;

  logic move;
  logic res_free;
  logic cur_data;
  logic cur_last;

  // Digit decode and accumulation for character references.
  logic [4:0]  digit;
  logic        digit_ok;
  logic [20:0] code_acc;

  always_comb begin
    if (in_byte_r >= 8'h30 && in_byte_r <= 8'h39) begin
      digit = 5'(in_byte_r - 8'h30);
    end else if (in_byte_r >= 8'h61 && in_byte_r <= 8'h66) begin
      digit = 5'(in_byte_r - 8'h57);
    end else if (in_byte_r >= 8'h41 && in_byte_r <= 8'h46) begin
      digit = 5'(in_byte_r - 8'h37);
    end else begin
      digit = 5'd31;
    end
    if (hex_r) begin
      digit_ok = (digit < 5'd16) && (code_r <= HEX_LIMIT);
      code_acc = {code_r[16:0], 4'b0000} + {16'd0, digit};
    end else begin
      digit_ok = (digit < 5'd10) && (code_r <= DEC_LIMIT);
      code_acc = {code_r[17:0], 3'b000} + {code_r[19:0], 1'b0} + {16'd0, digit};
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    name_nxt     = name_r;
    name_cnt_nxt = name_cnt_r;
    code_nxt     = code_r;
    hex_nxt      = hex_r;
    seen_nxt     = seen_r;
    res_nxt      = '0;

    unique case (mode_r)
      MODE_TEXT: begin
        if (in_byte_r == CH_AMP) begin
          mode_nxt     = MODE_NAME;
          name_nxt     = '0;
          name_cnt_nxt = '0;
          code_nxt     = '0;
          hex_nxt      = 1'b0;
          seen_nxt     = 1'b0;
        end else if (valid_char({13'd0, in_byte_r})) begin
          res_nxt.bytes[0] = in_byte_r;
          res_nxt.dcnt     = 3'd1;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      MODE_NAME: begin
        priority if (in_byte_r == CH_SEMI) begin
          mode_nxt     = MODE_TEXT;
          res_nxt.dcnt = 3'd1;
          priority if (name_cnt_r == 3'd3 && name_r == NAME_AMP) begin
            res_nxt.bytes[0] = CH_AMP;
          end else if (name_cnt_r == 3'd2 && name_r == NAME_LT) begin
            res_nxt.bytes[0] = CH_LT;
          end else if (name_cnt_r == 3'd2 && name_r == NAME_GT) begin
            res_nxt.bytes[0] = CH_GT;
          end else if (name_cnt_r == 3'd4 && name_r == NAME_QUOT) begin
            res_nxt.bytes[0] = CH_QUOT;
          end else if (name_cnt_r == 3'd4 && name_r == NAME_APOS) begin
            res_nxt.bytes[0] = CH_APOS;
          end else begin
            mode_nxt     = MODE_ERROR;
            res_nxt.dcnt = 3'd0;
          end
        end else if (name_cnt_r == 3'd0 && in_byte_r == CH_HASH) begin
          mode_nxt = MODE_HASH;
        end else if (name_cnt_r >= 3'd4) begin
          mode_nxt = MODE_ERROR;
        end else begin
          name_nxt     = {name_r[23:0], in_byte_r};
          name_cnt_nxt = name_cnt_r + 3'd1;
        end
      end
      MODE_HASH: begin
        priority if (in_byte_r == CH_SEMI) begin
          mode_nxt = MODE_ERROR;
        end else if (in_byte_r == CH_X) begin
          hex_nxt  = 1'b1;
          mode_nxt = MODE_DIGITS;
        end else if (digit_ok) begin
          code_nxt = code_acc;
          seen_nxt = 1'b1;
          mode_nxt = MODE_DIGITS;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      MODE_DIGITS: begin
        if (in_byte_r == CH_SEMI) begin
          if (seen_r && valid_char(code_r)) begin
            mode_nxt = MODE_TEXT;
            priority if (code_r < UTF8_2B_BASE) begin
              res_nxt.bytes[0] = code_r[7:0];
              res_nxt.dcnt     = 3'd1;
            end else if (code_r < UTF8_3B_BASE) begin
              res_nxt.bytes[0] = {3'b110, code_r[10:6]};
              res_nxt.bytes[1] = {2'b10, code_r[5:0]};
              res_nxt.dcnt     = 3'd2;
            end else if (code_r < UTF8_4B_BASE) begin
              res_nxt.bytes[0] = {4'b1110, code_r[15:12]};
              res_nxt.bytes[1] = {2'b10, code_r[11:6]};
              res_nxt.bytes[2] = {2'b10, code_r[5:0]};
              res_nxt.dcnt     = 3'd3;
            end else begin
              res_nxt.bytes[0] = {5'b11110, code_r[20:18]};
              res_nxt.bytes[1] = {2'b10, code_r[17:12]};
              res_nxt.bytes[2] = {2'b10, code_r[11:6]};
              res_nxt.bytes[3] = {2'b10, code_r[5:0]};
              res_nxt.dcnt     = 3'd4;
            end
          end else begin
            mode_nxt = MODE_ERROR;
          end
        end else if (digit_ok) begin
          code_nxt = code_acc;
          seen_nxt = 1'b1;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      default: begin
        mode_nxt = MODE_ERROR;
      end
    endcase

    // The final byte of a text adds a status result and starts afresh.
    if (in_last_r) begin
      res_nxt.status = 1'b1;
      res_nxt.ok     = (mode_nxt == MODE_TEXT);
      mode_nxt       = MODE_TEXT;
      name_nxt       = '0;
      name_cnt_nxt   = '0;
      code_nxt       = '0;
      hex_nxt        = 1'b0;
      seen_nxt       = 1'b0;
    end
    res_nxt.total = res_nxt.dcnt + {2'b00, res_nxt.status};
  end

  // The result register is free once its last result is taken.
  assign cur_data  = (idx_r < res_r.dcnt);
  assign cur_last  = (idx_r == res_r.total - 3'd1);
  assign res_free  = !res_valid_r || (out_tready && cur_last);
  assign move      = in_valid_r && res_free;
  assign in_tready = !in_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_TEXT;
      name_r     <= '0;
      name_cnt_r <= '0;
      code_r     <= '0;
      hex_r      <= 1'b0;
      seen_r     <= 1'b0;
    end else if (move) begin
      mode_r     <= mode_nxt;
      name_r     <= name_nxt;
      name_cnt_r <= name_cnt_nxt;
      code_r     <= code_nxt;
      hex_r      <= hex_nxt;
      seen_r     <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (move) begin
      res_valid_r <= (res_nxt.total != 3'd0);
      idx_r       <= '0;
    end else if (res_valid_r && out_tready) begin
      idx_r <= idx_r + 3'd1;
      if (cur_last) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r <= res_nxt;
    end
  end

  // Data bytes go out first, the status result (if any) last.
  assign out_tvalid = res_valid_r;
  assign out_tuser  = !cur_data;
  assign out_tlast  = cur_last;
  assign out_tdata  = {7'd0, !cur_data && res_r.ok,
                       cur_data ? res_r.bytes[idx_r[1:0]] : 8'h00};

  // The read index never runs past the results of the held beat.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (idx_r < res_r.total))
    else $error("result index beyond held results");

  // A final byte always produces a status result.
  a_last_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
    (move && in_last_r) |=> (res_valid_r && res_r.status))
    else $error("final byte without status result");

  // A final byte always leaves the parser in plain text with no entity open.
  a_last_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (move && in_last_r) |=> (mode_r == MODE_TEXT && name_cnt_r == 3'd0 && !seen_r))
    else $error("parser state not cleared after final byte");

  // The status result is always the last result of its beat.
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("status result not marked last");

  // An entity name never collects more than four bytes.
  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    name_cnt_r <= 3'd4)
    else $error("entity name count overflow");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for xml_entity_unescape: directed and random XML texts
// are streamed in, every result beat is checked against a behavioural model of the
// unescaper kept here. Depends on xeu_pkg and the xml_entity_unescape top level.
module testbench
  import xeu_pkg::*;
();

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BYTES = 350;
  localparam int MID_PAUSE_AT = 250;     // random bytes queued before the second drain pause
  localparam int HOLD_AFTER   = 140;     // accepted beats before the long receiver hold
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 30;

  // One byte of escaped text waiting to be sent. A set drain flag makes the sender
  // wait until every outstanding result has come back before it offers this byte.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       drain;
  } text_beat_t;

  // One result beat as the decoder should produce it.
  typedef struct packed {
    logic [7:0] b;
    logic       status;
    logic       ok;
    logic       last;
  } result_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] in_byte
  logic        in_tlast   = 1'b0;   // in_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] out_byte, [8] ok, [15:9] zero
  logic        out_tuser;           // is_status
  logic        out_tlast;           // result_last

  text_beat_t   text_q[$];          // escaped bytes still to be sent
  result_beat_t unescaped_q[$];     // decoded beats still to arrive
  logic [7:0]   frag[$];            // text under construction
  logic [7:0]   dec_bytes[$];       // data bytes decoded from the current beat

  // Model state of the decoder.
  xeu_mode_t   dec_mode   = MODE_TEXT;
  logic [31:0] ent_name   = '0;
  logic [2:0]  ent_len    = '0;
  logic [20:0] cref_val   = '0;
  logic        cref_hex   = 1'b0;
  logic        cref_digit = 1'b0;

  int n_cycles   = 0;
  int n_errors   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_texts    = 0;
  int n_clean    = 0;
  int n_broken   = 0;

  xml_entity_unescape i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioural model of the unescaper.
  // ---------------------------------------------------------------------------

  // XML character ranges: tab, LF, CR and the three blocks that skip the
  // surrogates and the two non-characters at the top of the basic plane.
  function automatic logic legal_code(input logic [20:0] c);
    if (c == 21'd9 || c == 21'd10 || c == 21'd13) return 1'b1;
    if (c < 21'h20) return 1'b0;
    if (c < 21'hd800) return 1'b1;
    if (c < 21'he000) return 1'b0;
    if (c < 21'hfffe) return 1'b1;
    if (c < 21'h10000) return 1'b0;
    return c <= CODE_MAX;
  endfunction

  task automatic drop_entity();
    ent_name   = '0;
    ent_len    = '0;
    cref_val   = '0;
    cref_hex   = 1'b0;
    cref_digit = 1'b0;
  endtask

  // Appends one decoded data byte for the beat under way.
  task automatic emit_byte(input logic [7:0] v);
    dec_bytes = {dec_bytes, v};
  endtask

  // One digit of a character reference. The overflow test looks at the
  // accumulator before the digit is added, as the hardware does.
  task automatic add_digit(input logic [7:0] b);
    int unsigned radix;
    int unsigned d;
    radix = cref_hex ? 16 : 10;
    d = 99;
    if (b >= "0" && b <= "9") d = 32'(b - 8'h30);
    else if (b >= "a" && b <= "f") d = 32'(b - 8'h57);
    else if (b >= "A" && b <= "F") d = 32'(b - 8'h37);
    if (d >= radix || cref_val > CODE_MAX / radix) begin
      dec_mode = MODE_ERROR;
      drop_entity();
    end else begin
      cref_val   = 21'(cref_val * radix + d);
      cref_digit = 1'b1;
      dec_mode   = MODE_DIGITS;
    end
  endtask

  // Advances the model by one accepted byte and queues the beats it causes.
  task automatic unescape_byte(input logic [7:0] b, input logic fin);
    logic [20:0]  c;
    result_beat_t r;
    int           n_res;
    dec_bytes.delete();
    case (dec_mode)
      MODE_TEXT: begin
        if (b == CH_AMP) begin
          drop_entity();
          dec_mode = MODE_NAME;
        end else if (legal_code({13'd0, b})) begin
          emit_byte(b);
        end else begin
          dec_mode = MODE_ERROR;
        end
      end
      MODE_NAME: begin
        if (b == CH_SEMI) begin
          dec_mode = MODE_TEXT;
          if (ent_len == 3'd3 && ent_name == NAME_AMP) emit_byte(CH_AMP);
          else if (ent_len == 3'd2 && ent_name == NAME_LT) emit_byte(CH_LT);
          else if (ent_len == 3'd2 && ent_name == NAME_GT) emit_byte(CH_GT);
          else if (ent_len == 3'd4 && ent_name == NAME_QUOT) emit_byte(CH_QUOT);
          else if (ent_len == 3'd4 && ent_name == NAME_APOS) emit_byte(CH_APOS);
          else dec_mode = MODE_ERROR;
          drop_entity();
        end else if (ent_len == 3'd0 && b == CH_HASH) begin
          dec_mode = MODE_HASH;
        end else if (ent_len >= 3'd4) begin
          dec_mode = MODE_ERROR;
          drop_entity();
        end else begin
          ent_name = {ent_name[23:0], b};
          ent_len  = ent_len + 3'd1;
        end
      end
      MODE_HASH: begin
        if (b == CH_SEMI) begin
          dec_mode = MODE_ERROR;
          drop_entity();
        end else if (b == CH_X) begin
          cref_hex = 1'b1;
          dec_mode = MODE_DIGITS;
        end else begin
          add_digit(b);
        end
      end
      MODE_DIGITS: begin
        if (b == CH_SEMI) begin
          c = cref_val;
          if (cref_digit && legal_code(c)) begin
            // UTF-8 encoding of the code point.
            if (c < 21'h80) begin
              emit_byte(c[7:0]);
            end else if (c < 21'h800) begin
              emit_byte({3'b110, c[10:6]});
              emit_byte({2'b10, c[5:0]});
            end else if (c < 21'h10000) begin
              emit_byte({4'b1110, c[15:12]});
              emit_byte({2'b10, c[11:6]});
              emit_byte({2'b10, c[5:0]});
            end else begin
              emit_byte({5'b11110, c[20:18]});
              emit_byte({2'b10, c[17:12]});
              emit_byte({2'b10, c[11:6]});
              emit_byte({2'b10, c[5:0]});
            end
            dec_mode = MODE_TEXT;
          end else begin
            dec_mode = MODE_ERROR;
          end
          drop_entity();
        end else begin
          add_digit(b);
        end
      end
      default: dec_mode = MODE_ERROR;  // swallow everything until the final byte
    endcase

    n_res = dec_bytes.size() + (fin ? 1 : 0);
    foreach (dec_bytes[i]) begin
      r.b      = dec_bytes[i];
      r.status = 1'b0;
      r.ok     = 1'b0;
      r.last   = (i == n_res - 1);
      unescaped_q = {unescaped_q, r};
    end
    if (fin) begin
      // The status beat closes the text; the next byte starts afresh.
      r.b      = 8'h00;
      r.status = 1'b1;
      r.ok     = (dec_mode == MODE_TEXT);
      r.last   = 1'b1;
      unescaped_q = {unescaped_q, r};
      dec_mode = MODE_TEXT;
      drop_entity();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] v);
    frag = {frag, v};
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Moves the text under construction into the send queue, tlast on its final byte.
  task automatic close_text(input bit drain);
    text_beat_t t;
    foreach (frag[i]) begin
      t.b     = frag[i];
      t.last  = (i == frag.size() - 1);
      t.drain = drain && (i == 0);
      text_q = {text_q, t};
    end
    n_texts++;
    frag.delete();
  endtask

  // A code point that the decoder must accept, weighted towards each UTF-8
  // length and the edges of every legal range.
  function automatic logic [20:0] pick_code();
    logic [20:0] bounds [10] = '{21'h20, 21'h7f, 21'h80, 21'h7ff, 21'h800,
                                 21'hd7ff, 21'he000, 21'hfffd, 21'h10000, 21'h10ffff};
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 2))
          0: return 21'd9;
          1: return 21'd10;
          default: return 21'd13;
        endcase
      end
      1: return 21'($urandom_range(32, 127));
      2: return 21'($urandom_range(128, 2047));
      3: return 21'($urandom_range(2048, 55295));
      4: return 21'($urandom_range(57344, 65533));
      5: return 21'($urandom_range(65536, 1114111));
      default: return bounds[$urandom_range(0, 9)];
    endcase
  endfunction

  // A well-formed piece of text, noise bytes apart: raw bytes, a named entity or a reference.
  task automatic add_segment();
    string names [5] = '{"amp", "lt", "gt", "quot", "apos"};
    string s;
    string z;
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) z = "00";
    else z = "";
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 9))
            0: begin
              case ($urandom_range(0, 2))
                0: b = 8'h09;
                1: b = 8'h0a;
                default: b = 8'h0d;
              endcase
            end
            1, 2: b = 8'($urandom_range(128, 255));
            default: b = 8'($urandom_range(32, 127));
          endcase
          if (b == CH_AMP) b = "a";
          // Now and then a byte of pure noise, controls and '&' included.
          if ($urandom_range(0, 99) < 3) b = 8'($urandom_range(0, 255));
          add_byte(b);
        end
      end
      4, 5: put_str({"&", names[$urandom_range(0, 4)], ";"});
      6: put_str({"&#", z, $sformatf("%0d", pick_code()), ";"});
      default: begin
        s = $sformatf("%0h", pick_code());
        for (int i = 0; i < s.len(); i++)
          if (s[i] >= "a" && s[i] <= "f" && $urandom_range(0, 1)) s[i] = s[i] - 8'h20;
        put_str({"&#x", z, s, ";"});
      end
    endcase
  endtask

  // A piece of text that puts the decoder into its error state.
  task automatic add_broken();
    logic [20:0] bad_codes [9] = '{21'h0, 21'h8, 21'hb, 21'h1f, 21'hd800, 21'hdfff,
                                    21'hfffe, 21'hffff, 21'h110000};
    logic [7:0] b;
    int k;
    case ($urandom_range(0, 8))
      0: begin
        do k = $urandom_range(0, 31); while (k == 9 || k == 10 || k == 13);
        add_byte(8'(k));
      end
      1: put_str("&;");
      2: begin
        if ($urandom_range(0, 1)) put_str("&#x;");
        else put_str("&#;");
      end
      3: begin
        // Unknown or over-long name; any byte but ';' (and '#' in first place) is part of the name.
        put_str("&");
        repeat ($urandom_range(1, 7)) begin
          if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(97, 122));
          else b = 8'($urandom_range(0, 255));
          if (b == CH_SEMI) b = "z";
          add_byte(b);
        end
        put_str(";");
      end
      4: put_str($sformatf("&#X%0h;", pick_code()));
      5: begin
        if ($urandom_range(0, 1)) put_str("&#12a;");
        else put_str("&#x1g;");
      end
      6: begin
        if ($urandom_range(0, 1)) put_str("&#99999999;");
        else put_str("&#x7fffffff;");
      end
      default: begin
        k = $urandom_range(0, 8);
        if ($urandom_range(0, 1)) put_str($sformatf("&#%0d;", bad_codes[k]));
        else put_str($sformatf("&#x%0h;", bad_codes[k]));
      end
    endcase
  endtask

  task automatic random_text(input bit drain);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 99) < 8) add_broken();
      else add_segment();
    end
    // A few texts end with an entity still open.
    if ($urandom_range(0, 99) < 5) begin
      if ($urandom_range(0, 1)) put_str("&am");
      else put_str("&#x4");
    end
    close_text(drain);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. The predictor
  // runs on every accepted beat, so the expected beats are always queued
  // before the decoder can produce them.
  // ---------------------------------------------------------------------------
  int         burst_left = 0;
  int         gap_left   = 0;
  text_beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        unescape_byte(in_tdata, in_tlast);
        n_accepted++;
      end
      // A beat on offer and not taken must be held as it is.
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (text_q.size() == 0
                     || (text_q[0].drain && unescaped_q.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          next_beat = text_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_beat.b;
          in_tlast  <= next_beat.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a ready pattern in one of four styles, redrawn at random, plus one
  // long hold once enough beats have gone in, so that the result register stays
  // full and the decoder has to stall its input.
  // ---------------------------------------------------------------------------
  int rx_cycle  = 0;
  int rx_style  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (rx_cycle % 5 < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  result_beat_t oldest;

  task automatic report_mismatch(input string what);
    if (n_errors < MAX_REPORTS) $display("tb: mismatch at cycle %0d: %s", n_cycles, what);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (unescaped_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h user %b with nothing expected",
                                  out_tdata, out_tuser));
      end else begin
        oldest = unescaped_q.pop_front();
        n_checked++;
        if (oldest.status && oldest.ok) n_clean++;
        else if (oldest.status) n_broken++;
        if (out_tuser !== oldest.status)
          report_mismatch($sformatf("is_status %b, expected %b", out_tuser, oldest.status));
        if (out_tdata[8] !== oldest.ok)
          report_mismatch($sformatf("ok %b, expected %b", out_tdata[8], oldest.ok));
        if (out_tlast !== oldest.last)
          report_mismatch($sformatf("result_last %b, expected %b", out_tlast, oldest.last));
        // The byte of a status beat carries no meaning.
        if (!oldest.status && out_tdata[7:0] !== oldest.b)
          report_mismatch($sformatf("out_byte %h, expected %h", out_tdata[7:0], oldest.b));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: run stopped by the watchdog after %0d cycles", n_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int n_rand;
    bit mid_pause_done;
    n_rand = 0;
    mid_pause_done = 1'b0;

    // Directed texts: the top byte value and the largest code point in
    // mixed-case hex, a lone NUL, an empty entity, an entity left open at the
    // end, and a plain decimal reference.
    add_byte(8'hff);
    put_str("&#x10FfFF;");
    close_text(1'b0);
    add_byte(8'h00);
    close_text(1'b0);
    put_str("&;");
    close_text(1'b0);
    put_str("&amp");
    close_text(1'b0);
    put_str("&#65;");
    close_text(1'b0);

    // Random texts. The first waits for the directed results to drain; one
    // later text pauses the sender the same way.
    while (n_rand < RANDOM_BYTES) begin
      k_sized: begin
        int before_sz;
        before_sz = text_q.size();
        if (n_rand == 0) begin
          random_text(1'b1);
        end else if (!mid_pause_done && n_rand >= MID_PAUSE_AT) begin
          mid_pause_done = 1'b1;
          random_text(1'b1);
        end else begin
          random_text(1'b0);
        end
        n_rand += text_q.size() - before_sz;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_tvalid) @(posedge clk);
    while (unescaped_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d texts, %0d bytes in, %0d result beats checked",
             n_texts, n_accepted, n_checked);
    $display("tb: %0d texts decoded cleanly, %0d ended in error, %0d mismatches",
             n_clean, n_broken, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### xml_entity_unescape.f
src/xeu_pkg.sv
src/xml_entity_unescape.sv
tb/testbench.sv
